>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the vertex rotator. They compile to
// nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define ASSERT_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define ASSERT_CHK(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Shared types, codes and elaboration-time CORDIC constants of the vertex
// rotator.
// ----------------------------------------------------------------------------
package avr_pkg;

   localparam int ANGLE_W   = 18;   // input angle, degrees * 256
   localparam int ANG_RED_W = 16;   // folded angle, within +-90 degrees
   localparam int CV_W      = 62;   // CORDIC datapath, signed Q60
   localparam int FRONT_LAT = 3;    // front register stages ahead of the first cell
   localparam int UNIT_LO_W = 24;
   localparam int UNIT_HI_W = 24;

   localparam logic signed [ANGLE_W:0] ANG_FULL    = 19'sd92160;
   localparam logic signed [ANGLE_W:0] ANG_FULL2   = 19'sd184320;
   localparam logic signed [ANGLE_W:0] ANG_HALF    = 19'sd46080;
   localparam logic signed [ANGLE_W:0] ANG_QUARTER = 19'sd23040;

   // rotation axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                   valid;
      logic signed [CV_W-1:0] x;
      logic signed [CV_W-1:0] y;
      logic signed [CV_W-1:0] z;
   } cvec_type;

   // Shift-subtract division, only ever evaluated at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) in Q60 by its power series, truncating each term
   function automatic logic [63:0] atan_recip(input logic [63:0] n);
      logic [63:0]        t;
      logic [63:0]        nn;
      logic [63:0]        term;
      logic signed [63:0] sum;
      t   = udiv64(64'd1 << 60, n);
      nn  = n * n;
      sum = '0;
      for (int k = 0; k < 64; k++) begin
         if (t != 64'd0) begin
            term = udiv64(t, 64'(2 * k + 1));
            if (k[0]) sum = sum - $signed(term);
            else      sum = sum + $signed(term);
            t = udiv64(t, nn);
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] pi4_q60();
      return (64'd4 * atan_recip(64'd5)) - atan_recip(64'd239);
   endfunction

   function automatic logic [63:0] atan_q60(input int stage);
      if (stage == 0) return pi4_q60();
      return atan_recip(64'd1 << stage);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res  = '0;
      bitv = 64'd1 << 62;
      rem  = n;
      for (int i = 0; i < 32; i++) begin
         if (bitv > rem) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // start vector length: folds the CORDIC gain of the given stage count
   function automatic logic [63:0] gain_q60(input int stages);
      logic [63:0] q;
      q = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (i < stages) q = q - udiv64(q, (64'd1 << (2 * i)) + 64'd1);
      end
      return isqrt64(q) << 29;
   endfunction

   // one angle step (1/256 degree) in Q60 radians
   localparam logic [63:0] UNIT_Q60 = udiv64(64'd4 * pi4_q60(), 64'd46080);

endpackage

>>> design/avr_chan_if.sv
// ----------------------------------------------------------------------------
// avr_chan_if
// Valid/ready channels of the vertex rotator: request (vertex, axis, angle)
// and response (rotated vertex).
// ----------------------------------------------------------------------------
interface avr_req_if #(parameter int COORD_WIDTH = 32) ();
   import avr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   logic signed [COORD_WIDTH-1:0] coord_z;
   logic signed [COORD_WIDTH-1:0] coord_w;
   logic signed [ANGLE_W-1:0]     angle;

   modport source (
      output valid, func, coord_x, coord_y, coord_z, coord_w, angle,
      input  ready
   );
   modport sink (
      input  valid, func, coord_x, coord_y, coord_z, coord_w, angle,
      output ready
   );
endinterface

interface avr_rsp_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic signed [COORD_WIDTH-1:0] out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

>>> design/avr_front.sv
// ----------------------------------------------------------------------------
// avr_front
// Angle front end: reduce to +-90 degrees, scale to Q60 radians and load the
// CORDIC start vector. Three register stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avr_front #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [avr_pkg::ANGLE_W-1:0] angle,
   output avr_pkg::cvec_type                 vec_out,
   output logic                              flip_out
);
   import avr_pkg::*;

   localparam logic signed [CV_W-1:0]    GAIN    = CV_W'(gain_q60(CORDIC_STAGES));
   localparam logic [UNIT_HI_W-1:0]      UNIT_HI = UNIT_Q60[UNIT_LO_W+UNIT_HI_W-1:UNIT_LO_W];
   localparam logic [UNIT_LO_W-1:0]      UNIT_LO = UNIT_Q60[UNIT_LO_W-1:0];
   localparam int                        PH_W    = ANG_RED_W + UNIT_HI_W + 1;
   localparam int                        PL_W    = ANG_RED_W + UNIT_LO_W + 1;

   logic signed [ANGLE_W:0]   a_ext, a_up1, a_up2, a_dn, a_mod, a_half, a_fold;
   logic                      flip_in;
   logic                      va_ff, vb_ff, vc_ff;
   logic signed [ANG_RED_W-1:0] ang_ff;
   logic                      flip_a_ff, flip_b_ff, flip_c_ff;
   logic signed [PH_W-1:0]    prod_hi_ff;
   logic signed [PL_W-1:0]    prod_lo_ff;
   logic signed [CV_W-1:0]    z_in, z_ff;

   always_comb begin
      a_ext = {angle[ANGLE_W-1], angle};
      a_up1 = a_ext + ANG_FULL;
      a_up2 = a_ext + ANG_FULL2;
      a_dn  = a_ext - ANG_FULL;
      // bring into one turn, then into the half turn around zero
      if (a_ext[ANGLE_W]) a_mod = a_up1[ANGLE_W] ? a_up2 : a_up1;
      else                a_mod = (a_ext >= ANG_FULL) ? a_dn : a_ext;
      a_half = (a_mod >= ANG_HALF) ? (a_mod - ANG_FULL) : a_mod;
      // fold beyond a quarter turn; coefficients get negated later
      flip_in = 1'b0;
      a_fold  = a_half;
      if (a_half > ANG_QUARTER) begin
         a_fold  = a_half - ANG_HALF;
         flip_in = 1'b1;
      end else if (a_half < -ANG_QUARTER) begin
         a_fold  = a_half + ANG_HALF;
         flip_in = 1'b1;
      end
   end

   assign z_in = (CV_W'(prod_hi_ff) <<< UNIT_LO_W) + CV_W'(prod_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      if (en) begin
         ang_ff     <= a_fold[ANG_RED_W-1:0];
         flip_a_ff  <= flip_in;
         prod_hi_ff <= PH_W'(ang_ff) * PH_W'($signed({1'b0, UNIT_HI}));
         prod_lo_ff <= PL_W'(ang_ff) * PL_W'($signed({1'b0, UNIT_LO}));
         flip_b_ff  <= flip_a_ff;
         z_ff       <= z_in;
         flip_c_ff  <= flip_b_ff;
      end
   end

   assign vec_out.valid = vc_ff;
   assign vec_out.x     = GAIN;
   assign vec_out.y     = '0;
   assign vec_out.z     = z_ff;
   assign flip_out      = flip_c_ff;

   `ASSERT_NEXT(a_ang_range, clock, reset, en && in_valid, (ang_ff <= ANG_QUARTER) && (ang_ff >= -ANG_QUARTER))
   `ASSERT_NEXT(a_flip_follow, clock, reset, en, flip_b_ff == $past(flip_a_ff))

endmodule

>>> design/avr_cell.sv
// ----------------------------------------------------------------------------
// avr_cell
// One CORDIC micro-rotation with its own atan constant; registers the
// rotated vector for the next cell.
// ----------------------------------------------------------------------------
module avr_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  avr_pkg::cvec_type vec_in,
   output avr_pkg::cvec_type vec_out
);
   import avr_pkg::*;

   localparam logic signed [CV_W-1:0] ATAN = CV_W'(atan_q60(STAGE));

   logic signed [CV_W-1:0] dx, dy;
   cvec_type               vec_in_next, vec_ff;

   always_comb begin
      dx = $signed(vec_in.y) >>> STAGE;
      dy = $signed(vec_in.x) >>> STAGE;
      vec_in_next.valid = vec_in.valid;
      // rotate towards zero residual angle
      if (!vec_in.z[CV_W-1]) begin
         vec_in_next.x = vec_in.x - dx;
         vec_in_next.y = vec_in.y + dy;
         vec_in_next.z = vec_in.z - ATAN;
      end else begin
         vec_in_next.x = vec_in.x + dx;
         vec_in_next.y = vec_in.y - dy;
         vec_in_next.z = vec_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
      end else if (en) begin
         vec_ff.valid <= vec_in_next.valid;
      end
      if (en) begin
         vec_ff.x <= vec_in_next.x;
         vec_ff.y <= vec_in_next.y;
         vec_ff.z <= vec_in_next.z;
      end
   end

   assign vec_out = vec_ff;

endmodule

>>> design/avr_combine.sv
// ----------------------------------------------------------------------------
// avr_combine
// Rounds cos/sin to coefficients, forms the plane rotation with four
// multipliers, rounds to Q16.16 and saturates. Three register stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avr_combine #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [avr_pkg::CV_W-1:0] cos_q60,
   input  logic signed [avr_pkg::CV_W-1:0] sin_q60,
   input  logic                           flip,
   input  logic [1:0]                     func,
   input  logic signed [COORD_WIDTH-1:0]  crd_x,
   input  logic signed [COORD_WIDTH-1:0]  crd_y,
   input  logic signed [COORD_WIDTH-1:0]  crd_z,
   input  logic signed [COORD_WIDTH-1:0]  crd_w,
   output logic                           out_valid,
   output logic signed [COORD_WIDTH-1:0]  out_x,
   output logic signed [COORD_WIDTH-1:0]  out_y,
   output logic signed [COORD_WIDTH-1:0]  out_z,
   output logic signed [COORD_WIDTH-1:0]  out_w
);
   import avr_pkg::*;

   localparam int CF  = 61 - COORD_WIDTH;      // coefficient fraction bits
   localparam int CFW = CF + 2;
   localparam int SH  = COORD_WIDTH - 1;       // Q60 to coefficient shift
   localparam int PW  = CFW + COORD_WIDTH;
   localparam int SW  = 64;
   localparam logic signed [CV_W-1:0] COEF_HALF = CV_W'(64'd1 << (SH - 1));
   localparam logic signed [SW-1:0]   SUM_HALF  = SW'(64'd1 << (CF - 1));
   localparam logic signed [SW-1:0]   SAT_HI    = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0]   SAT_LO    = ~SAT_HI;

   function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
      if (v > SAT_HI) return SAT_HI[COORD_WIDTH-1:0];
      if (v < SAT_LO) return SAT_LO[COORD_WIDTH-1:0];
      return v[COORD_WIDTH-1:0];
   endfunction

   // stage 1: coefficients
   logic signed [CV_W-1:0]        c_sum, s_sum, c_shr, s_shr;
   logic signed [CFW-1:0]         c_co, s_co, c_in, s_in;
   logic                          v1_ff;
   logic signed [CFW-1:0]         c1_ff, s1_ff;
   logic [1:0]                    func1_ff;
   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff, z1_ff, w1_ff;

   // stage 2: products
   logic signed [COORD_WIDTH-1:0] op_p, op_q;
   logic                          v2_ff;
   logic signed [PW-1:0]          cp_ff, sq_ff, sp_ff, cq_ff;
   logic [1:0]                    func2_ff;
   logic signed [COORD_WIDTH-1:0] x2_ff, y2_ff, z2_ff, w2_ff;

   // stage 3: sums, rounding, saturation, routing
   logic signed [SW-1:0]          sum_p, sum_q, rnd_p, rnd_q;
   logic signed [COORD_WIDTH-1:0] sat_p, sat_q;
   logic signed [COORD_WIDTH-1:0] out_x_in, out_y_in, out_z_in;
   logic                          v3_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff, out_w_ff;

   always_comb begin
      c_sum = cos_q60 + COEF_HALF;
      s_sum = sin_q60 + COEF_HALF;
      c_shr = c_sum >>> SH;
      s_shr = s_sum >>> SH;
      c_co  = c_shr[CFW-1:0];
      s_co  = s_shr[CFW-1:0];
      c_in  = flip ? -c_co : c_co;
      s_in  = flip ? -s_co : s_co;
   end

   // plane coordinates (p, q): out_p = c*p - s*q, out_q = s*p + c*q
   always_comb begin
      unique case (func1_ff)
         AXIS_X: begin
            op_p = y1_ff;
            op_q = z1_ff;
         end
         AXIS_Y: begin
            op_p = z1_ff;
            op_q = x1_ff;
         end
         default: begin
            op_p = x1_ff;
            op_q = y1_ff;
         end
      endcase
   end

   always_comb begin
      sum_p = SW'(cp_ff) - SW'(sq_ff) + SUM_HALF;
      sum_q = SW'(sp_ff) + SW'(cq_ff) + SUM_HALF;
      rnd_p = sum_p >>> CF;
      rnd_q = sum_q >>> CF;
      sat_p = sat(rnd_p);
      sat_q = sat(rnd_q);
      out_x_in = x2_ff;
      out_y_in = y2_ff;
      out_z_in = z2_ff;
      unique case (func2_ff)
         AXIS_X: begin
            out_y_in = sat_p;
            out_z_in = sat_q;
         end
         AXIS_Y: begin
            out_z_in = sat_p;
            out_x_in = sat_q;
         end
         AXIS_Z: begin
            out_x_in = sat_p;
            out_y_in = sat_q;
         end
         default: ;  // no rotation: pass the vertex
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         c1_ff    <= c_in;
         s1_ff    <= s_in;
         func1_ff <= func;
         x1_ff    <= crd_x;
         y1_ff    <= crd_y;
         z1_ff    <= crd_z;
         w1_ff    <= crd_w;

         cp_ff    <= PW'(c1_ff) * PW'(op_p);
         sq_ff    <= PW'(s1_ff) * PW'(op_q);
         sp_ff    <= PW'(s1_ff) * PW'(op_p);
         cq_ff    <= PW'(c1_ff) * PW'(op_q);
         func2_ff <= func1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
         w2_ff    <= w1_ff;

         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
         out_w_ff <= w2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;
   assign out_w     = out_w_ff;

   `ASSERT_NEXT(a_no_rot_pass, clock, reset, en && v2_ff && (func2_ff != AXIS_X) && (func2_ff != AXIS_Y) && (func2_ff != AXIS_Z), (out_x_ff == $past(x2_ff)) && (out_y_ff == $past(y2_ff)) && (out_z_ff == $past(z2_ff)))
   `ASSERT_NEXT(a_w_pass, clock, reset, en && v2_ff, out_w_ff == $past(w2_ff))

endmodule

>>> design/axis_vertex_rotator.sv
// ----------------------------------------------------------------------------
// axis_vertex_rotator
// Rotates a homogeneous Q16.16 vertex about the X, Y or Z axis by an angle
// in 1/256 degree steps, using a pipelined CORDIC chain for cos/sin.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    func, coord_x/y/z/w, angle
//   rsp_if   out  valid/ready    out_x/y/z/w
//
// One beat per clock while the output queue is not full; from accept to
// rsp_if a beat passes three front stages, the cell chain, three combine
// stages and the output queue register.
// Reset is synchronous and clears all valid bits and the output queue.
// The whole pipeline holds while the two-entry output queue is full;
// req_if.ready comes from the queue count register alone.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_vertex_rotator #(
   parameter int COORD_WIDTH   = 32,
   parameter int CORDIC_STAGES = 16
) (
   input logic       clock,
   input logic       reset,
   avr_req_if.sink   req_if,
   avr_rsp_if.source rsp_if
);
   import avr_pkg::*;

   localparam int LINE = FRONT_LAT + CORDIC_STAGES;

   typedef struct packed {
      logic [1:0]                    func;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] w;
   } side_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] w;
   } beat_type;

   logic          advance;
   logic          front_flip;
   cvec_type      chain [CORDIC_STAGES+1];
   side_type      side_in;
   side_type      side_ff [LINE];
   logic          flip_ff [CORDIC_STAGES];

   logic          comb_valid;
   beat_type      comb_beat;
   logic          push, pop;
   logic [1:0]    count_ff, count_in;
   beat_type      head_ff, head_in, tail_ff, tail_in;

   assign advance      = (count_ff != 2'd2);
   assign req_if.ready = advance;

   avr_front #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .in_valid (req_if.valid),
      .angle    (req_if.angle),
      .vec_out  (chain[0]),
      .flip_out (front_flip)
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      avr_cell #(
         .STAGE (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .vec_in  (chain[g]),
         .vec_out (chain[g+1])
      );
   end

   // vertex and axis ride alongside the angle path
   assign side_in = '{func: req_if.func, x: req_if.coord_x, y: req_if.coord_y,
                      z: req_if.coord_z, w: req_if.coord_w};

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LINE; i++) side_ff[i] <= side_ff[i-1];
         flip_ff[0] <= front_flip;
         for (int i = 1; i < CORDIC_STAGES; i++) flip_ff[i] <= flip_ff[i-1];
      end
   end

   avr_combine #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (chain[CORDIC_STAGES].valid),
      .cos_q60   (chain[CORDIC_STAGES].x),
      .sin_q60   (chain[CORDIC_STAGES].y),
      .flip      (flip_ff[CORDIC_STAGES-1]),
      .func      (side_ff[LINE-1].func),
      .crd_x     (side_ff[LINE-1].x),
      .crd_y     (side_ff[LINE-1].y),
      .crd_z     (side_ff[LINE-1].z),
      .crd_w     (side_ff[LINE-1].w),
      .out_valid (comb_valid),
      .out_x     (comb_beat.x),
      .out_y     (comb_beat.y),
      .out_z     (comb_beat.z),
      .out_w     (comb_beat.w)
   );

   // two-entry output queue decouples rsp_if.ready from the pipeline
   assign push = comb_valid && advance;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) head_in = comb_beat;
            else                  tail_in = comb_beat;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = comb_beat;
            end else begin
               head_in = tail_ff;
               tail_in = comb_beat;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_if.valid = (count_ff != 2'd0);
   assign rsp_if.out_x = head_ff.x;
   assign rsp_if.out_y = head_ff.y;
   assign rsp_if.out_z = head_ff.z;
   assign rsp_if.out_w = head_ff.w;

   `ASSERT_CHK(a_queue_bound, clock, reset, count_ff != 2'd3)
   `ASSERT_NEXT(a_stall_hold, clock, reset, !advance, $stable(chain[CORDIC_STAGES].valid) && $stable(comb_valid))
   `ASSERT_NEXT(a_full_drain, clock, reset, (count_ff == 2'd2) && !rsp_if.ready, count_ff == 2'd2)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertex rotator. A directed table covers the
// field extremes, every axis, the pass-through axis code, angles beyond
// +-90 degrees and patterns outside +-360 degrees. A random stream follows
// under four handshake phases and one long output hold-off. Four table rows
// hold fixed results; others are checked by a bit-exact CORDIC predictor here.
// ----------------------------------------------------------------------------
module tb;
   import avr_pkg::*;

   localparam int COORD_W   = 32;
   localparam int STAGES    = 16;
   localparam int COEF_FRAC = 61 - COORD_W;
   localparam int LATENCY   = STAGES + 7;
   localparam int HOLD_LEN  = 150;
   localparam int N_DIR     = 23;
   localparam int N_RANDOM  = 260;
   localparam int N_BURST   = 64;

   localparam logic [1:0] AXIS_NONE = 2'd3;   // no rotation, vertex passes

   localparam int DEG = 256;
   localparam longint TURN         = 92160;
   localparam longint HALF_TURN    = 46080;
   localparam longint QUARTER_TURN = 23040;

   localparam longint COEF_HALF = longint'(1) << (60 - COEF_FRAC - 1);
   localparam longint OUT_HALF  = longint'(1) << (COEF_FRAC - 1);
   localparam longint CMAX      = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint CMIN      = -CMAX - 1;

   localparam logic signed [COORD_W-1:0] MAXC = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] MINC = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;
   localparam int A_TOP = 131071;
   localparam int A_BOT = -131072;

   typedef struct {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] x, y, z, w;
      logic signed [ANGLE_W-1:0] angle;
   } vertex_type;

   typedef struct {
      logic signed [COORD_W-1:0] x, y, z, w;
   } rot_type;

   typedef struct {
      vertex_type v;
      bit         typed;
      rot_type    want;
   } dir_row_type;

   logic clock;
   logic reset;

   avr_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
   avr_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_ch ();

   axis_vertex_rotator #(
      .COORD_WIDTH(COORD_W),
      .CORDIC_STAGES(STAGES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   longint cordic_atan [STAGES];
   longint cordic_gain;
   longint angle_lsb_rad;

   rot_type rotated_due [$];
   int   idle_pct;
   int   stall_pct;
   bit   hold_req;
   int   items_sent;
   int   results_checked;
   int   mismatch_count;

   // atan(1/n) in Q60 from its power series, truncating each term
   function automatic longint atan_inv(input longint unsigned n);
      longint unsigned t, nn, k;
      longint acc;
      t = (64'd1 << 60) / n;
      nn = n * n;
      acc = 0;
      k = 0;
      while (t != 0) begin
         if (k[0]) acc -= longint'(t / (2 * k + 1));
         else acc += longint'(t / (2 * k + 1));
         t = t / nn;
         k++;
      end
      return acc;
   endfunction

   // CORDIC constants: angle table, folded gain and the angle LSB in radians
   initial begin
      longint unsigned q, res, b;
      longint quarter_pi;
      quarter_pi = 4 * atan_inv(5) - atan_inv(239);
      cordic_atan[0] = quarter_pi;
      for (int i = 1; i < STAGES; i++) cordic_atan[i] = atan_inv(64'd1 << i);
      q = 64'd1 << 62;
      for (int i = 0; i < STAGES; i++) q -= q / ((64'd1 << (2 * i)) + 1);
      res = 0;
      b = 64'd1 << 62;
      while (b > q) b >>= 2;
      while (b != 0) begin
         if (q >= res + b) begin
            q -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      cordic_gain = longint'(res << 29);
      angle_lsb_rad = (4 * quarter_pi) / HALF_TURN;
   end

   // round a Q(16+COEF_FRAC) sum back to Q16.16 and saturate
   function automatic logic signed [COORD_W-1:0] to_q16(input longint acc);
      longint r;
      r = (acc + OUT_HALF) >>> COEF_FRAC;
      if (r > CMAX) r = CMAX;
      if (r < CMIN) r = CMIN;
      return r[COORD_W-1:0];
   endfunction

   function automatic rot_type rotate_vertex(input vertex_type v);
      longint a, cx, sy, zr, dx, dy, c, s, px, py, pz;
      bit      flip;
      rot_type r;
      a = v.angle;
      flip = 1'b0;
      a = a % TURN;
      if (a < 0) a += TURN;
      if (a >= HALF_TURN) a -= TURN;
      // fold into +-90 degrees, negate the coefficients afterwards
      if (a > QUARTER_TURN) begin
         a -= HALF_TURN;
         flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
         a += HALF_TURN;
         flip = 1'b1;
      end
      cx = cordic_gain;
      sy = 0;
      zr = a * angle_lsb_rad;
      for (int i = 0; i < STAGES; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (zr >= 0) begin
            cx -= dx;
            sy += dy;
            zr -= cordic_atan[i];
         end else begin
            cx += dx;
            sy -= dy;
            zr += cordic_atan[i];
         end
      end
      c = (cx + COEF_HALF) >>> (60 - COEF_FRAC);
      s = (sy + COEF_HALF) >>> (60 - COEF_FRAC);
      if (flip) begin
         c = -c;
         s = -s;
      end
      px = v.x;
      py = v.y;
      pz = v.z;
      r.x = v.x;
      r.y = v.y;
      r.z = v.z;
      r.w = v.w;
      case (v.func)
         AXIS_X: begin
            r.y = to_q16(c * py - s * pz);
            r.z = to_q16(s * py + c * pz);
         end
         AXIS_Y: begin
            r.x = to_q16(c * px + s * pz);
            r.z = to_q16(c * pz - s * px);
         end
         AXIS_Z: begin
            r.x = to_q16(c * px - s * py);
            r.y = to_q16(s * px + c * py);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic vertex_type vtx(input logic [1:0] f,
                                      input logic signed [COORD_W-1:0] x, y, z, w,
                                      input int a);
      vertex_type v;
      v.func = f;
      v.x = x;
      v.y = y;
      v.z = z;
      v.w = w;
      v.angle = ANGLE_W'(a);
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(9))
         0: return MAXC;
         1: return MINC;
         2, 3: return int'($urandom_range(32'h3FFFF)) - 32'h20000;
         4, 5, 6: return int'($urandom_range(32'h1FF_FFFF)) - 32'h100_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      if ($urandom_range(15) == 0) v.func = AXIS_NONE;
      else v.func = 2'($urandom_range(2));
      v.x = random_coord();
      v.y = random_coord();
      v.z = random_coord();
      v.w = random_coord();
      case ($urandom_range(7))
         0: v.angle = ANGLE_W'($urandom());
         1: v.angle = ANGLE_W'((int'($urandom_range(8)) - 4) * int'(QUARTER_TURN));
         default: v.angle = ANGLE_W'(int'($urandom_range(2 * TURN)) - int'(TURN));
      endcase
      return v;
   endfunction

   // offer one beat, hold it until accepted, then queue its rotation
   task automatic offer_vertex(input vertex_type v, input rot_type want);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.func    <= v.func;
      req_ch.coord_x <= v.x;
      req_ch.coord_y <= v.y;
      req_ch.coord_z <= v.z;
      req_ch.coord_w <= v.w;
      req_ch.angle   <= v.angle;
      do @(posedge clock); while (!req_ch.ready);
      rotated_due.push_back(want);
      items_sent++;
   endtask

   task automatic wait_drained();
      while (rotated_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls, or a long hold-off when asked for
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rot_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.x = rsp_ch.out_x;
         got.y = rsp_ch.out_y;
         got.z = rsp_ch.out_z;
         got.w = rsp_ch.out_w;
         if (rotated_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: %h %h %h %h", got.x, got.y, got.z, got.w);
         end else begin
            want = rotated_due.pop_front();
            results_checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.w !== want.w) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat %0d: want %h %h %h %h got %h %h %h %h",
                           results_checked, want.x, want.y, want.z, want.w,
                           got.x, got.y, got.z, got.w);
            end
         end
      end
   end

   initial begin
      dir_row_type dir_table [N_DIR];
      vertex_type  v;
      int          idle_sets  [4];
      int          stall_sets [4];
      idle_sets  = '{0, 72, 0, 28};
      stall_sets = '{0, 0, 72, 28};
      idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b0;
      items_sent = 0;
      results_checked = 0;
      mismatch_count = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = AXIS_X;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      req_ch.coord_z = '0;
      req_ch.coord_w = '0;
      req_ch.angle = '0;

      dir_table = '{
         '{vtx(AXIS_NONE, MAXC, MINC, MAXC, MINC, A_TOP), 1'b1, '{MAXC, MINC, MAXC, MINC}},
         '{vtx(AXIS_NONE, MINC, MAXC, 0, ONE, A_BOT), 1'b1, '{MINC, MAXC, 0, ONE}},
         '{vtx(AXIS_X, 0, 0, 0, MINC, 12345), 1'b1, '{0, 0, 0, MINC}},
         '{vtx(AXIS_Z, 0, 0, 0, MAXC, 360 * DEG), 1'b1, '{0, 0, 0, MAXC}},
         '{vtx(AXIS_X, ONE, ONE, 0, ONE, 0), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, ONE, 2 * ONE, 3 * ONE, ONE, 0), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, ONE, 0, 0, ONE, 90 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, 0, ONE, 0, ONE, -90 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, ONE, 0, ONE, ONE, 180 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, ONE, ONE, ONE, ONE, -180 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, -ONE, ONE, -ONE, ONE, 270 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, 3 * ONE, ONE, -ONE, ONE, 360 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, MAXC, MAXC, MAXC, ONE, 45 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, MINC, MINC, MINC, MINC, 180 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, MAXC, MINC, MINC, MAXC, -45 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, ONE, -ONE, 0, ONE, A_TOP), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, 0, 2 * ONE, ONE, ONE, A_BOT), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, ONE, 0, 2 * ONE, ONE, 90 * DEG + 1), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, 2 * ONE, ONE, 0, ONE, -90 * DEG - 1), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, 0, MAXC, MINC, ONE, 1), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Y, MINC, 0, MAXC, ONE, -1), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_Z, -1, 1, -1, 1, 135 * DEG), 1'b0, '{0, 0, 0, 0}},
         '{vtx(AXIS_X, -ONE, 5 * ONE, -7 * ONE, -ONE, -360 * DEG), 1'b0, '{0, 0, 0, 0}}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIR; r++) begin
         if (dir_table[r].typed) offer_vertex(dir_table[r].v, dir_table[r].want);
         else offer_vertex(dir_table[r].v, rotate_vertex(dir_table[r].v));
      end
      // pause the input until the pipeline has emptied
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_sets[p];
         stall_pct = stall_sets[p];
         for (int n = 0; n < N_RANDOM; n++) begin
            v = random_vertex();
            offer_vertex(v, rotate_vertex(v));
         end
         if (p == 0) begin
            // back-pressure: hold the output while beats keep coming in
            hold_req = 1'b1;
            for (int n = 0; n < N_BURST; n++) begin
               v = random_vertex();
               offer_vertex(v, rotate_vertex(v));
            end
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);

      $display("%0d vertices rotated (%0d from the table), all axes and angle folds,",
               items_sent, N_DIR);
      $display("under four idle/stall mixes and a long output hold; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
